// ===== sv/sdq_pkg.sv =====
package sdq_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUT  = 1'b1;

    localparam int MAX_RESULTS   = 16;
    localparam int WAKE_CNT_BITS = 5;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REFUSED  = 2'd1,
        KIND_WOKEN    = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_WAKE
    } state_t;

    typedef struct packed {
        logic insert;
        logic decrement;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== sv/sdq_if.sv =====
interface sdq_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  task_id;
    logic [31:0] sleep_ticks;

    modport source (output valid, output operation, output task_id, output sleep_ticks,
                    input ready);
    modport sink (input valid, input operation, input task_id, input sleep_ticks,
                  output ready);
endinterface

interface sdq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] woken_task;
    logic       last;

    modport source (output valid, output result_kind, output woken_task, output last,
                    input ready);
    modport sink (input valid, input result_kind, input woken_task, input last,
                  output ready);
endinterface

// ===== sv/sdq_cell.sv =====
module sdq_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdq_pkg::cell_ctrl_t   ctrl,
    input  logic [7:0]            put_task,
    input  logic [TIME_BITS-1:0]  put_time,
    input  logic                  left_valid,
    input  logic                  left_ge,
    input  logic [7:0]            left_task,
    input  logic [TIME_BITS-1:0]  left_rem,
    input  logic                  right_valid,
    input  logic [7:0]            right_task,
    input  logic [TIME_BITS-1:0]  right_rem,
    output logic                  cell_valid,
    output logic                  cell_ge,
    output logic [7:0]            cell_task,
    output logic [TIME_BITS-1:0]  cell_rem
);

    logic                 valid_reg, valid_next;
    logic [7:0]           task_reg, task_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;

    assign cell_valid = valid_reg;
    assign cell_task  = task_reg;
    assign cell_rem   = rem_reg;
    assign cell_ge    = valid_reg && (rem_reg >= put_time);

    // Each cell holds the full remaining time of its task, so the queue stays
    // sorted and an insertion point is found by one compare in every cell.
    always_comb
    begin
        valid_next = valid_reg;
        task_next  = task_reg;
        rem_next   = rem_reg;
        if (ctrl.insert)
        begin
            if (left_ge)
            begin
                valid_next = 1'b1;
                task_next  = left_task;
                rem_next   = left_rem;
            end
            else if (left_valid && (cell_ge || !valid_reg))
            begin
                valid_next = 1'b1;
                task_next  = put_task;
                rem_next   = put_time;
            end
        end
        else if (ctrl.decrement)
        begin
            if (valid_reg)
            begin
                rem_next = rem_reg - {{(TIME_BITS-1){1'b0}}, 1'b1};
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = right_valid;
            task_next  = right_task;
            rem_next   = right_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        rem_reg  <= rem_next;
    end

endmodule

// ===== sv/sleep_delta_queue.sv =====
// Channel | Dir | Payload                            | Handshake
// req     | in  | operation, task_id, sleep_ticks    | valid / ready
// rsp     | out | result_kind, woken_task, last      | valid / ready
//
// A put's result is ready in the output register on the next cycle. A tick ages
// the queue unless the head is already due, then wakes each due task, up to
// MAX_RESULTS per tick, by one shift of the cell chain for each task that wakes.
// Reset clears every cell's valid bit and the control state; the queue is empty.
// A stalled result holds the chain, and no new item is taken while a tick wakes.
module sleep_delta_queue #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    sdq_req_if.sink   req,
    sdq_rsp_if.source rsp
);

    localparam logic [63:0] TIME_MAX = {64{1'b1}} >> (64 - TIME_BITS);

    sdq_pkg::state_t   state_reg, state_next;
    sdq_pkg::cell_ctrl_t ctrl;

    logic [sdq_pkg::WAKE_CNT_BITS-1:0] wake_cnt_reg, wake_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_kind_reg, out_kind_next;
    logic [7:0]           out_task_reg, out_task_next;
    logic                 out_last_reg, out_last_next;

    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  ge_vec;
    logic [7:0]           task_arr [CAPACITY];
    logic [TIME_BITS-1:0] rem_arr  [CAPACITY];

    logic [63:0]          sleep_wide;
    logic [63:0]          sleep_sat;
    logic [TIME_BITS-1:0] put_time;

    logic in_fire, slot_free, full, head_due, can_wake, emit, wake_last;

    assign sleep_wide = {32'd0, req.sleep_ticks};
    always_comb
    begin
        if (sleep_wide == 64'd0)
        begin
            sleep_sat = 64'd1;
        end
        else if (sleep_wide > TIME_MAX)
        begin
            sleep_sat = TIME_MAX;
        end
        else
        begin
            sleep_sat = sleep_wide;
        end
    end
    assign put_time = sleep_sat[TIME_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                 l_valid, l_ge, r_valid;
            logic [7:0]           l_task, r_task;
            logic [TIME_BITS-1:0] l_rem, r_rem;

            if (gi == 0)
            begin : g_head
                assign l_valid = 1'b1;
                assign l_ge    = 1'b0;
                assign l_task  = 8'd0;
                assign l_rem   = '0;
            end
            else
            begin : g_body
                assign l_valid = valid_vec[gi-1];
                assign l_ge    = ge_vec[gi-1];
                assign l_task  = task_arr[gi-1];
                assign l_rem   = rem_arr[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_task  = 8'd0;
                assign r_rem   = '0;
            end
            else
            begin : g_inner
                assign r_valid = valid_vec[gi+1];
                assign r_task  = task_arr[gi+1];
                assign r_rem   = rem_arr[gi+1];
            end

            sdq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .put_task    (req.task_id),
                .put_time    (put_time),
                .left_valid  (l_valid),
                .left_ge     (l_ge),
                .left_task   (l_task),
                .left_rem    (l_rem),
                .right_valid (r_valid),
                .right_task  (r_task),
                .right_rem   (r_rem),
                .cell_valid  (valid_vec[gi]),
                .cell_ge     (ge_vec[gi]),
                .cell_task   (task_arr[gi]),
                .cell_rem    (rem_arr[gi])
            );
        end
    endgenerate

    assign slot_free = !out_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;
    assign full      = valid_vec[CAPACITY-1];
    assign head_due  = valid_vec[0] && (rem_arr[0] == '0);
    assign can_wake  = head_due &&
                       (wake_cnt_reg < sdq_pkg::WAKE_CNT_BITS'(sdq_pkg::MAX_RESULTS));
    assign wake_last = !(valid_vec[1] && (rem_arr[1] == '0)) ||
                       (wake_cnt_reg == sdq_pkg::WAKE_CNT_BITS'(sdq_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                if (in_fire && (req.operation == sdq_pkg::OP_TICK))
                begin
                    state_next = sdq_pkg::ST_WAKE;
                end
            end
            sdq_pkg::ST_WAKE:
            begin
                if (!can_wake || (slot_free && wake_last))
                begin
                    state_next = sdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = 1'b0;
        emit           = 1'b0;
        ctrl           = '0;
        case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                req.ready = slot_free;
                ctrl.insert = in_fire && (req.operation == sdq_pkg::OP_PUT) && !full;
                ctrl.decrement = in_fire && (req.operation == sdq_pkg::OP_TICK) &&
                                 valid_vec[0] && (rem_arr[0] != '0);
            end
            sdq_pkg::ST_WAKE:
            begin
                emit     = can_wake && slot_free;
                ctrl.pop = emit;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wake_cnt_next = wake_cnt_reg;
        if (in_fire)
        begin
            wake_cnt_next = '0;
        end
        else if (emit)
        begin
            wake_cnt_next = wake_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_task_next  = out_task_reg;
        out_last_next  = out_last_reg;
        if (in_fire && (req.operation == sdq_pkg::OP_PUT))
        begin
            out_valid_next = 1'b1;
            out_kind_next  = full ? sdq_pkg::KIND_REFUSED : sdq_pkg::KIND_ACCEPTED;
            out_task_next  = 8'd0;
            out_last_next  = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = sdq_pkg::KIND_WOKEN;
            out_task_next  = task_arr[0];
            out_last_next  = wake_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdq_pkg::ST_IDLE;
            wake_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wake_cnt_reg  <= wake_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_task_reg <= out_task_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.woken_task  = out_task_reg;
    assign rsp.last        = out_last_reg;

`ifndef SYNTH
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
        else $error("Occupied cells are not contiguous from the head.");

    a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (req.operation == sdq_pkg::OP_PUT) |=> out_valid_reg && out_last_reg)
        else $error("A put item did not produce its result.");

    a_wake_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wake_cnt_reg <= sdq_pkg::WAKE_CNT_BITS'(sdq_pkg::MAX_RESULTS))
        else $error("Too many tasks woken by one tick.");

    a_wake_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdq_pkg::ST_WAKE) |-> !req.ready)
        else $error("Input taken while a tick is still waking tasks.");
`endif

endmodule
